// ===== sv/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape / UTF-8 decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_CLOSED = 2'd1,
		KIND_ENDED  = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	localparam int CpW = 31;

	typedef struct packed {
		kind_t          kind;
		logic [CpW-1:0] code_point;
		logic           last_of_run;
	} result_t;

	// Special characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CONT_MASK = 8'h3F;

	// Control codes produced by escapes
	localparam logic [7:0] CC_BS = 8'h08;
	localparam logic [7:0] CC_FF = 8'h0C;
	localparam logic [7:0] CC_LF = 8'h0A;
	localparam logic [7:0] CC_CR = 8'h0D;
	localparam logic [7:0] CC_HT = 8'h09;

	// Number of continuation bytes a lead byte announces, zero if not a lead
	function automatic logic [2:0] lead_extra(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		if (b >= 8'hFE)      n = 3'd0;
		else if (b >= 8'hFC) n = 3'd5;
		else if (b >= 8'hF8) n = 3'd4;
		else if (b >= 8'hF0) n = 3'd3;
		else if (b >= 8'hE0) n = 3'd2;
		else if (b >= 8'hC0) n = 3'd1;
		return n;
	endfunction

endpackage

// ===== sv/json_string_unescape_utf8_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Takes the bytes of a JSON string, one item per cycle while in_stall is low,
// and returns decoded code points with close / end / error markers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel : in_valid / in_stall with data_byte and buffer_end.
//   Output channel: out_valid / out_stall with kind, code_point, last_of_run.
//   An item moves when valid is high and stall is low at a rising clk edge.
//   The first byte after reset, or after a close, buffer end or error, is
//   taken as the opening quote and dropped.
//   Results are registered: an accepted byte waits in the input register,
//   and the result register loads from it once the output can take it.
//   Throughput: one byte per cycle while in_stall is low. A byte with two
//   results (a character, then the buffer-end marker) parks the marker in
//   the spare second result and holds the input register until the marker
//   enters the result register. The opening quote, a backslash and lead and
//   continuation bytes of an unfinished sequence give no result.
//   Stall: when out_stall is high a valid result and the spare second
//   result hold; in_stall rises as soon as the input register cannot drain.
//   Reset: arst_n clears all valid flags and the decoder state.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core #(
	parameter int MAX_EXTRA_BYTES = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 buffer_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output jsu_pkg::kind_t       kind,
	output logic [jsu_pkg::CpW-1:0] code_point,
	output logic                 last_of_run
);
	import jsu_pkg::*;

	localparam int LeftW = $clog2(MAX_EXTRA_BYTES + 1);

	// Input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       end_s1;
	logic       go_s1;

	// Decoder state
	logic             awaiting_q, escape_q;
	logic [LeftW-1:0] left_q;
	logic [CpW-1:0]   accum_q;
	logic             awaiting_d, escape_d;
	logic [LeftW-1:0] left_d;
	logic [CpW-1:0]   accum_d;

	// Output register and spare second result
	logic    out_valid_q, pend_valid_q;
	result_t out_q, pend_q;

	// Results of the current byte
	logic    p_valid, e_valid, done;
	result_t p_res, e_res;
	logic [2:0] extra;
	logic [7:0] lead_mask;

	// Handshake
	assign go_s1    = valid_s1 && !pend_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			end_s1  <= buffer_end;
		end
	end

	// Per-byte decode
	always_comb begin
		awaiting_d = awaiting_q;
		escape_d   = escape_q;
		left_d     = left_q;
		accum_d    = accum_q;
		p_valid    = 1'b0;
		p_res      = '{kind: KIND_CHAR, code_point: '0, last_of_run: 1'b0};
		done       = 1'b0;
		extra      = lead_extra(data_s1);
		lead_mask  = 8'h7F >> (extra + 3'd1);

		if (awaiting_q) begin
			awaiting_d = 1'b0;
			escape_d   = 1'b0;
			left_d     = '0;
			accum_d    = '0;
		end else if (left_q != '0) begin
			accum_d = {accum_q[CpW-7:0], data_s1[5:0] & CONT_MASK[5:0]};
			left_d  = left_q - LeftW'(1);
			if (left_q == LeftW'(1)) begin
				p_valid            = 1'b1;
				p_res.code_point   = accum_d;
			end
		end else if (escape_q) begin
			escape_d = 1'b0;
			p_valid  = 1'b1;
			case (data_s1)
				CH_QUOTE:  p_res.code_point = CpW'(CH_QUOTE);
				CH_BSLASH: p_res.code_point = CpW'(CH_BSLASH);
				CH_SLASH:  p_res.code_point = CpW'(CH_SLASH);
				CH_B:      p_res.code_point = CpW'(CC_BS);
				CH_F:      p_res.code_point = CpW'(CC_FF);
				CH_N:      p_res.code_point = CpW'(CC_LF);
				CH_R:      p_res.code_point = CpW'(CC_CR);
				CH_T:      p_res.code_point = CpW'(CC_HT);
				default: begin
					p_res.kind = KIND_ERROR;
					done       = 1'b1;
				end
			endcase
		end else if (data_s1 == CH_QUOTE) begin
			p_valid    = 1'b1;
			p_res.kind = KIND_CLOSED;
			done       = 1'b1;
		end else if (data_s1 == CH_BSLASH) begin
			escape_d = 1'b1;
		end else if (!data_s1[7]) begin
			p_valid          = 1'b1;
			p_res.code_point = CpW'(data_s1);
		end else if (extra == 3'd0 || 32'(extra) > MAX_EXTRA_BYTES) begin
			// stray continuation, 0xFE/0xFF, or a lead that is too long
			p_valid    = 1'b1;
			p_res.kind = KIND_ERROR;
			done       = 1'b1;
		end else begin
			accum_d = CpW'(data_s1 & lead_mask);
			left_d  = extra[LeftW-1:0];
		end

		// Buffer end while the string is still open
		e_valid = !done && end_s1;
		e_res   = '{kind: (left_d != '0) ? KIND_ERROR : KIND_ENDED,
			code_point: '0, last_of_run: 1'b1};

		// Terminated: back to the reset state
		if (done || e_valid) begin
			awaiting_d = 1'b1;
			escape_d   = 1'b0;
			left_d     = '0;
			accum_d    = '0;
		end
		p_res.last_of_run = !e_valid;
	end

	// Decoder state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			escape_q   <= 1'b0;
			left_q     <= '0;
			accum_q    <= '0;
		end else if (go_s1) begin
			awaiting_q <= awaiting_d;
			escape_q   <= escape_d;
			left_q     <= left_d;
			accum_q    <= accum_d;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q) begin
			if (!out_stall) begin
				pend_valid_q <= 1'b0;
			end
		end else if (go_s1) begin
			out_valid_q  <= p_valid || e_valid;
			pend_valid_q <= p_valid && e_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			if (!out_stall) begin
				out_q <= pend_q;
			end
		end else if (go_s1) begin
			out_q  <= p_valid ? p_res : e_res;
			pend_q <= e_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign code_point  = out_q.code_point;
	assign last_of_run = out_q.last_of_run;

endmodule
